/* hw/rtl/mat_pkg.sv */
// Shared types and constants for the multi-ant turmite block.
// Used by mat_front, mat_back and the top level; depends on nothing.
package mat_pkg;

  // Fixed sizes of the grid, the ant table and the rule strings
  localparam int unsigned MaxAnts   = 8;
  localparam int unsigned AntW      = 3;
  localparam int unsigned CoordW    = 8;
  localparam int unsigned DimW      = 9;
  localparam int unsigned MaxDim    = 256;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned GridDepth = 65536;
  localparam int unsigned CellW     = 4;
  localparam int unsigned LenW      = 5;
  localparam int unsigned MaxRules  = 16;
  localparam int unsigned RulesW    = 32;
  localparam int unsigned CountW    = 4;

  // Action field of an input word
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_READ = 2'd2
  } action_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_ACTIVE = 2'd2
  } reg_idx_e;

  // Command kinds passed from the front to the back
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_READ = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [AntW-1:0]     ant;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic [1:0]          heading;
    logic [RulesW-1:0]   rules;
    logic [LenW-1:0]     len;
    logic [CountW-1:0]   count;
  } cmd_t;

  typedef struct packed {
    logic [AntW-1:0]     ant;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic [1:0]          heading;
    logic [CellW-1:0]    cell_val;
    logic                last;
  } res_t;

  // Grid size in use, already clamped to 1..MaxDim
  typedef struct packed {
    logic [DimW-1:0]     width;
    logic [DimW-1:0]     height;
  } grid_cfg_t;

endpackage

/* hw/rtl/mat_fifo.sv */
// Small first-in first-out queue of flat words, used for commands and results.
// Stand-alone; no package needed.
module mat_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/mat_front.sv */
// Front end: accepts input words, decodes the action and builds a command.
// Depends on mat_pkg for the command type and action codes.
module mat_front (
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [1:0]                  action_i,
  input  logic [mat_pkg::AntW-1:0]    ant_index_i,
  input  logic [mat_pkg::CoordW-1:0]  pos_x_i,
  input  logic [mat_pkg::CoordW-1:0]  pos_y_i,
  input  logic [1:0]                  heading_i,
  input  logic [mat_pkg::RulesW-1:0]  rule_codes_i,
  input  logic [mat_pkg::LenW-1:0]    rule_length_i,
  input  logic [mat_pkg::CountW-1:0]  active_ants_i,
  input  logic                        clearing_i,
  input  logic                        cmd_full_i,
  output logic                        cmd_push_o,
  output mat_pkg::cmd_t               cmd_o
);

  logic                        accept;
  logic [mat_pkg::CountW-1:0]  ant_count;
  logic [mat_pkg::LenW-1:0]    len_sat;

  // Hold off input while the grid is being cleared or the queue is full
  assign full_o = cmd_full_i | clearing_i;
  assign accept = push_i & ~full_o;

  // Saturate the ant count and the rule length
  always_comb begin
    ant_count = active_ants_i;
    if (active_ants_i > mat_pkg::CountW'(mat_pkg::MaxAnts)) begin
      ant_count = mat_pkg::CountW'(mat_pkg::MaxAnts);
    end
    len_sat = rule_length_i;
    if (rule_length_i == '0) begin
      len_sat = mat_pkg::LenW'(1);
    end else if (rule_length_i > mat_pkg::LenW'(mat_pkg::MaxRules)) begin
      len_sat = mat_pkg::LenW'(mat_pkg::MaxRules);
    end
  end

  // Classify: drop empty ticks and unused actions, queue the rest
  always_comb begin
    cmd_o.kind    = mat_pkg::CMD_TICK;
    cmd_o.ant     = ant_index_i;
    cmd_o.x       = pos_x_i;
    cmd_o.y       = pos_y_i;
    cmd_o.heading = heading_i;
    cmd_o.rules   = rule_codes_i;
    cmd_o.len     = len_sat;
    cmd_o.count   = ant_count;
    cmd_push_o    = 1'b0;
    case (action_i)
      mat_pkg::ACT_TICK: begin
        cmd_o.kind = mat_pkg::CMD_TICK;
        cmd_push_o = accept & (ant_count != '0);
      end
      mat_pkg::ACT_LOAD: begin
        cmd_o.kind = mat_pkg::CMD_LOAD;
        cmd_push_o = accept;
      end
      mat_pkg::ACT_READ: begin
        cmd_o.kind = mat_pkg::CMD_READ;
        cmd_push_o = accept;
      end
      default: begin
        cmd_push_o = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/mat_back.sv */
// Back end: ant table, cell grid memory and the sequencer that runs commands.
// Depends on mat_pkg for command, result and grid size types.
module mat_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mat_pkg::grid_cfg_t cfg_i,
  input  logic               cmd_valid_i,
  input  mat_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output mat_pkg::res_t      res_o,
  output logic               clearing_o
);

  localparam int unsigned AntW   = mat_pkg::AntW;
  localparam int unsigned CoordW = mat_pkg::CoordW;
  localparam int unsigned DimW   = mat_pkg::DimW;
  localparam int unsigned AddrW  = mat_pkg::AddrW;
  localparam int unsigned CellW  = mat_pkg::CellW;
  localparam int unsigned LenW   = mat_pkg::LenW;
  localparam int unsigned CountW = mat_pkg::CountW;
  localparam int unsigned RulesW = mat_pkg::RulesW;
  localparam int unsigned StepW  = $clog2(CoordW);
  localparam int unsigned ModW   = DimW + CoordW - 1;
  localparam int unsigned MulW   = CoordW + DimW;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_CALC  = 6'b000100,
    ST_MOD   = 6'b001000,
    ST_ADDR  = 6'b010000,
    ST_EXEC  = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    HD_UP    = 2'd0,
    HD_RIGHT = 2'd1,
    HD_DOWN  = 2'd2,
    HD_LEFT  = 2'd3
  } heading_e;

  // Remainder of a small value by the rule length, one conditional subtract a bit
  function automatic logic [CellW-1:0] cell_wrap(input logic [LenW-1:0] val,
                                                 input logic [LenW-1:0] len);
    logic [2*LenW-1:0] r;
    logic [2*LenW-1:0] t;
    r = (2*LenW)'(val);
    for (int k = LenW - 1; k >= 0; k--) begin
      t = (2*LenW)'(len) << k;
      if (r >= t) begin
        r = r - t;
      end
    end
    return r[CellW-1:0];
  endfunction

  // Control registers
  state_e              state_q, state_d;
  logic [AddrW-1:0]    clr_q, clr_d;
  logic [AntW-1:0]     ant_cnt_q, ant_cnt_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                is_read_q, is_read_d;

  // Datapath registers
  logic [CoordW-1:0]   x_q, x_d, y_q, y_d;
  logic [AddrW-1:0]    prod_q, prod_d, addr_q, addr_d;
  logic                in_range_q, in_range_d;
  logic [CoordW-1:0]   rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [CellW-1:0]    rd_q;

  // Ant table
  logic [CoordW-1:0]   col_q   [mat_pkg::MaxAnts];
  logic [CoordW-1:0]   row_q   [mat_pkg::MaxAnts];
  logic [1:0]          hd_q    [mat_pkg::MaxAnts];
  logic [RulesW-1:0]   rules_q [mat_pkg::MaxAnts];
  logic [LenW-1:0]     len_q   [mat_pkg::MaxAnts];

  logic                pos_we, hd_we, prog_we;
  logic [AntW-1:0]     ant_widx;
  logic [CoordW-1:0]   ant_col_d, ant_row_d;
  logic [1:0]          ant_hd_d;

  // Grid memory
  logic [CellW-1:0]    grid_q [mat_pkg::GridDepth];
  logic                mem_we, mem_re;
  logic [AddrW-1:0]    mem_waddr;
  logic [CellW-1:0]    mem_wdata;

  // Current ant and shared multiplier
  logic [CoordW-1:0]   cur_col, cur_row;
  logic [1:0]          cur_hd;
  logic [RulesW-1:0]   cur_rules;
  logic [LenW-1:0]     cur_len;
  logic [CoordW-1:0]   mul_a;
  logic [MulW-1:0]     mul_full;

  // Step logic
  logic [ModW-1:0]     w_sh, h_sh;
  logic [CoordW-1:0]   rem_x_n, rem_y_n;
  logic [1:0]          code, new_hd;
  logic [CellW-1:0]    new_cell;
  logic [CoordW-1:0]   nx, ny;
  logic                last_ant;

  assign cur_col   = col_q[ant_cnt_q];
  assign cur_row   = row_q[ant_cnt_q];
  assign cur_hd    = hd_q[ant_cnt_q];
  assign cur_rules = rules_q[ant_cnt_q];
  assign cur_len   = len_q[ant_cnt_q];

  assign mul_a    = (state_q == ST_IDLE) ? cmd_i.y : cur_row;
  assign mul_full = MulW'(mul_a) * MulW'(cfg_i.width);

  assign clearing_o = (state_q == ST_CLEAR);

  // One restoring step of the position reduction
  always_comb begin
    w_sh    = ModW'(cfg_i.width) << step_q;
    h_sh    = ModW'(cfg_i.height) << step_q;
    rem_x_n = (ModW'(rem_x_q) >= w_sh) ? rem_x_q - CoordW'(w_sh) : rem_x_q;
    rem_y_n = (ModW'(rem_y_q) >= h_sh) ? rem_y_q - CoordW'(h_sh) : rem_y_q;
  end

  // Turn, bump the cell and move one step with wrap
  always_comb begin
    code = 2'd0;
    if (LenW'(rd_q) < cur_len) begin
      code = cur_rules[{rd_q, 1'b0} +: 2];
    end
    new_hd   = cur_hd + code;
    new_cell = cell_wrap(LenW'(rd_q) + LenW'(1), cur_len);
    nx = x_q;
    ny = y_q;
    case (new_hd)
      HD_UP: begin
        ny = (y_q == '0) ? CoordW'(cfg_i.height - DimW'(1)) : y_q - CoordW'(1);
      end
      HD_RIGHT: begin
        nx = ((DimW'(x_q) + DimW'(1)) == cfg_i.width) ? '0 : x_q + CoordW'(1);
      end
      HD_DOWN: begin
        ny = ((DimW'(y_q) + DimW'(1)) == cfg_i.height) ? '0 : y_q + CoordW'(1);
      end
      HD_LEFT: begin
        nx = (x_q == '0) ? CoordW'(cfg_i.width - DimW'(1)) : x_q - CoordW'(1);
      end
      default: begin
        nx = x_q;
      end
    endcase
    last_ant = ((CountW'(ant_cnt_q) + CountW'(1)) == count_q);
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    ant_cnt_d  = ant_cnt_q;
    count_d    = count_q;
    is_read_d  = is_read_q;
    x_d        = x_q;
    y_d        = y_q;
    prod_d     = prod_q;
    addr_d     = prod_q + AddrW'(x_q);
    in_range_d = in_range_q;
    rem_x_d    = rem_x_q;
    rem_y_d    = rem_y_q;
    step_d     = step_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = new_cell;
    pos_we     = 1'b0;
    hd_we      = 1'b0;
    prog_we    = 1'b0;
    ant_widx   = ant_cnt_q;
    ant_col_d  = nx;
    ant_row_d  = ny;
    ant_hd_d   = new_hd;
    res_o.ant      = ant_cnt_q;
    res_o.x        = nx;
    res_o.y        = ny;
    res_o.heading  = new_hd;
    res_o.cell_val = new_cell;
    res_o.last     = last_ant;

    case (state_q)
      // Sweep the grid to zero after reset
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(mat_pkg::GridDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end

      // Take the next command
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            mat_pkg::CMD_LOAD: begin
              pos_we    = 1'b1;
              hd_we     = 1'b1;
              prog_we   = 1'b1;
              ant_widx  = cmd_i.ant;
              ant_col_d = cmd_i.x;
              ant_row_d = cmd_i.y;
              ant_hd_d  = cmd_i.heading;
            end
            mat_pkg::CMD_READ: begin
              is_read_d  = 1'b1;
              x_d        = cmd_i.x;
              y_d        = cmd_i.y;
              prod_d     = mul_full[AddrW-1:0];
              in_range_d = (DimW'(cmd_i.x) < cfg_i.width) &&
                           (DimW'(cmd_i.y) < cfg_i.height);
              state_d    = ST_ADDR;
            end
            mat_pkg::CMD_TICK: begin
              is_read_d = 1'b0;
              count_d   = cmd_i.count;
              ant_cnt_d = '0;
              state_d   = ST_CALC;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // Form the row offset, or reduce a position left outside the grid
      ST_CALC: begin
        if ((DimW'(cur_col) < cfg_i.width) && (DimW'(cur_row) < cfg_i.height)) begin
          x_d     = cur_col;
          y_d     = cur_row;
          prod_d  = mul_full[AddrW-1:0];
          state_d = ST_ADDR;
        end else begin
          rem_x_d = cur_col;
          rem_y_d = cur_row;
          step_d  = StepW'(CoordW - 1);
          state_d = ST_MOD;
        end
      end

      // One quotient bit a cycle; store the reduced position and retry
      ST_MOD: begin
        rem_x_d = rem_x_n;
        rem_y_d = rem_y_n;
        step_d  = step_q - StepW'(1);
        if (step_q == '0) begin
          pos_we    = 1'b1;
          ant_col_d = rem_x_n;
          ant_row_d = rem_y_n;
          state_d   = ST_CALC;
        end
      end

      // Issue the grid read
      ST_ADDR: begin
        mem_re  = 1'b1;
        state_d = ST_EXEC;
      end

      // Emit the result; for a tick also write back the cell and update the ant
      ST_EXEC: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (is_read_q) begin
            res_o.ant      = '0;
            res_o.x        = x_q;
            res_o.y        = y_q;
            res_o.heading  = '0;
            res_o.cell_val = in_range_q ? rd_q : '0;
            res_o.last     = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            mem_we = 1'b1;
            pos_we = 1'b1;
            hd_we  = 1'b1;
            if (last_ant) begin
              state_d = ST_IDLE;
            end else begin
              ant_cnt_d = ant_cnt_q + AntW'(1);
              state_d   = ST_CALC;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      ant_cnt_q <= '0;
      count_q   <= '0;
      is_read_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      ant_cnt_q <= ant_cnt_d;
      count_q   <= count_d;
      is_read_q <= is_read_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    prod_q     <= prod_d;
    addr_q     <= addr_d;
    in_range_q <= in_range_d;
    rem_x_q    <= rem_x_d;
    rem_y_q    <= rem_y_d;
    step_q     <= step_d;
  end

  // Ant table writes: load, position reduction, step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mat_pkg::MaxAnts; i++) begin
        col_q[i]   <= '0;
        row_q[i]   <= '0;
        hd_q[i]    <= '0;
        rules_q[i] <= '0;
        len_q[i]   <= LenW'(1);
      end
    end else begin
      if (pos_we) begin
        col_q[ant_widx] <= ant_col_d;
        row_q[ant_widx] <= ant_row_d;
      end
      if (hd_we) begin
        hd_q[ant_widx] <= ant_hd_d;
      end
      if (prog_we) begin
        rules_q[ant_widx] <= cmd_i.rules;
        len_q[ant_widx]   <= cmd_i.len;
      end
    end
  end

  // Grid: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= grid_q[addr_d];
    end
  end

endmodule

/* hw/rtl/multi_ant_turmite_step.sv */
// Top level of the multi-ant turmite: configuration registers and the
// front / command queue / back / result queue chain. Uses mat_pkg,
// mat_front, mat_fifo and mat_back.
//
//   channel   handshake             payload
//   input     push / full           action_i .. rule_length_i
//   result    empty / pop           out_ant_o .. last_o
//   config    cfg_valid_i / ready   cfg_index_i, cfg_data_i
//
// In the back end a load is done in the idle state, a read passes through the
// address and execute states, and a tick runs calc, address and execute for
// each active ant, with a reduction and a retry of calc for an ant whose stored
// position lies outside the grid in use. After reset all 65536 grid cells are
// swept to zero, with full high. Otherwise input stalls only on a full command
// queue; the back end waits on a full result queue; results stay until popped.
module multi_ant_turmite_step #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  action_i,
  input  logic [mat_pkg::AntW-1:0]    ant_index_i,
  input  logic [mat_pkg::CoordW-1:0]  pos_x_i,
  input  logic [mat_pkg::CoordW-1:0]  pos_y_i,
  input  logic [1:0]                  heading_i,
  input  logic [mat_pkg::RulesW-1:0]  rule_codes_i,
  input  logic [mat_pkg::LenW-1:0]    rule_length_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [mat_pkg::AntW-1:0]    out_ant_o,
  output logic [mat_pkg::CoordW-1:0]  out_x_o,
  output logic [mat_pkg::CoordW-1:0]  out_y_o,
  output logic [1:0]                  out_heading_o,
  output logic [mat_pkg::CellW-1:0]   cell_value_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [mat_pkg::DimW-1:0]    cfg_data_i
);

  localparam int unsigned DimW   = mat_pkg::DimW;
  localparam int unsigned CountW = mat_pkg::CountW;
  localparam int unsigned CmdW   = $bits(mat_pkg::cmd_t);
  localparam int unsigned ResW   = $bits(mat_pkg::res_t);

  logic [DimW-1:0]    width_q, height_q;
  logic [CountW-1:0]  active_q;
  mat_pkg::grid_cfg_t grid_cfg;

  mat_pkg::cmd_t      front_cmd, back_cmd;
  mat_pkg::res_t      back_res, out_res;
  logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic               res_push, res_full;
  logic               clearing;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(mat_pkg::MaxDim);
      height_q <= DimW'(mat_pkg::MaxDim);
      active_q <= CountW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mat_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        mat_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        mat_pkg::REG_ACTIVE: active_q <= cfg_data_i[CountW-1:0];
        default: begin
          active_q <= active_q;
        end
      endcase
    end
  end

  // Clamp the grid size to 1..MaxDim
  always_comb begin
    grid_cfg.width = width_q;
    if (width_q == '0) begin
      grid_cfg.width = DimW'(1);
    end else if (width_q > DimW'(mat_pkg::MaxDim)) begin
      grid_cfg.width = DimW'(mat_pkg::MaxDim);
    end
    grid_cfg.height = height_q;
    if (height_q == '0) begin
      grid_cfg.height = DimW'(1);
    end else if (height_q > DimW'(mat_pkg::MaxDim)) begin
      grid_cfg.height = DimW'(mat_pkg::MaxDim);
    end
  end

  mat_front u_front (
    .push_i        (push),
    .full_o        (full),
    .action_i      (action_i),
    .ant_index_i   (ant_index_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .heading_i     (heading_i),
    .rule_codes_i  (rule_codes_i),
    .rule_length_i (rule_length_i),
    .active_ants_i (active_q),
    .clearing_i    (clearing),
    .cmd_full_i    (cmd_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (front_cmd)
  );

  mat_fifo #(
    .DEPTH (CMD_DEPTH),
    .WIDTH (CmdW)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (back_cmd),
    .empty_o (cmd_empty)
  );

  mat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (grid_cfg),
    .cmd_valid_i (~cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res),
    .clearing_o  (clearing)
  );

  mat_fifo #(
    .DEPTH (RES_DEPTH),
    .WIDTH (ResW)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  // Drive the result ports from the head of the result queue
  assign out_ant_o     = out_res.ant;
  assign out_x_o       = out_res.x;
  assign out_y_o       = out_res.y;
  assign out_heading_o = out_res.heading;
  assign cell_value_o  = out_res.cell_val;
  assign last_o        = out_res.last;

endmodule
